>>> design/gem_pkg.sv
// ----------------------------------------------------------------------------
// gem_pkg
// Shared types, selector codes and kernel weights of the gradient edge block.
// ----------------------------------------------------------------------------
package gem_pkg;

  typedef logic [7:0] pix_t;
  // one window column: [0] top row, [1] middle row, [2] bottom row
  typedef pix_t [2:0] win_col_t;
  typedef logic signed [2:0] wgt_t;
  typedef wgt_t [8:0] kernel_t;

  localparam logic [1:0] METHOD_SOBEL   = 2'd0;
  localparam logic [1:0] METHOD_ROBERTS = 2'd1;
  localparam logic [1:0] METHOD_PREWITT = 2'd2;

  localparam logic [1:0] DIR_X   = 2'd0;
  localparam logic [1:0] DIR_Y   = 2'd1;
  localparam logic [1:0] DIR_MAG = 2'd2;

  localparam logic [1:0] REG_METHOD = 2'd0;
  localparam logic [1:0] REG_DIR    = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  localparam int CFG_W = 11;

  // entry k is window position row*3+col
  localparam kernel_t K_SOBEL_X = '{3'sd1, 3'sd0, -3'sd1, 3'sd2, 3'sd0, -3'sd2,
                                    3'sd1, 3'sd0, -3'sd1};
  localparam kernel_t K_SOBEL_Y = '{3'sd1, 3'sd2, 3'sd1, 3'sd0, 3'sd0, 3'sd0,
                                    -3'sd1, -3'sd2, -3'sd1};
  localparam kernel_t K_PREW_X  = '{3'sd1, 3'sd0, -3'sd1, 3'sd1, 3'sd0, -3'sd1,
                                    3'sd1, 3'sd0, -3'sd1};
  localparam kernel_t K_PREW_Y  = '{3'sd1, 3'sd1, 3'sd1, 3'sd0, 3'sd0, 3'sd0,
                                    -3'sd1, -3'sd1, -3'sd1};

endpackage

>>> design/gem_ram.sv
// ----------------------------------------------------------------------------
// gem_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/gem_win_cell.sv
// ----------------------------------------------------------------------------
// gem_win_cell
// One column of the 3x3 window; loads the column of its right neighbor.
// ----------------------------------------------------------------------------
module gem_win_cell (
  input  logic              clk,
  input  logic              shift,
  input  gem_pkg::win_col_t din,
  output gem_pkg::win_col_t dout
);

  import gem_pkg::*;

  win_col_t col_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      col_r <= din;
    end
  end

  assign dout = col_r;

endmodule

>>> design/gradient_edge_magnitude_top.sv
// ----------------------------------------------------------------------------
// gradient_edge_magnitude_top
// Streaming Sobel / Roberts / Prewitt edge value (|Gx|, |Gy| or gradient magnitude) over a raster frame.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one transfer at a time; each result leaves
// W+1 input transfers after its own pixel, and W+1 flush ticks after the
// frame push out the tail. An item that completes no window passes only the
// idle state and the registered line-buffer read; one that does goes on
// through the kernel and select stages, the Euclidean magnitude also through
// the sum, the bit-per-cycle square root (8 steps) and rounding. A result
// still waiting in the output register holds the next one back. The line
// buffers need no clearing pass: rows outside the image are masked to zero.
module gradient_edge_magnitude_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // pixel[7:0]
  input  logic                      in_tuser,   // cmd (1 = flush tick)
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [7:0]                out_tdata,  // edge_value[7:0]
  output logic                      out_tlast,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_addr,
  input  logic [gem_pkg::CFG_W-1:0] cfg_wdata
);

  import gem_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_CALC, S_SEL, S_SUM, S_ROOT, S_RND, S_DONE
  } state_t;

  state_t             state_r;
  logic [1:0]         method_r;
  logic [1:0]         dir_r;
  logic [CFG_W-1:0]   width_r;
  logic [CFG_W-1:0]   height_r;
  logic [CW-1:0]      col_r;
  logic [RW-1:0]      row_r;
  pix_t               v_r;
  logic               rz_r, rh_r, cz_r, cw_r, last_r;
  logic signed [11:0] gx_r, gy_r;
  logic [21:0]        sx_r, sy_r, n_r;
  logic [7:0]         m_r;
  logic [2:0]         bit_r;
  pix_t               res_r;
  logic               out_valid_r;
  pix_t               out_data_r;
  logic               out_last_r;

  logic [WW-1:0]      w_c;
  logic [HW-1:0]      h_c;
  pix_t               top_rd, mid_rd;
  logic               ram_we;
  win_col_t           new_col, c2, c1, c0;
  logic               shift;

  // clamped frame size
  always_comb begin
    if (32'(width_r) < 32'd2) w_c = WW'(2);
    else if (32'(width_r) > 32'(MAX_WIDTH)) w_c = WW'(MAX_WIDTH);
    else w_c = WW'(width_r);
    if (32'(height_r) < 32'd2) h_c = HW'(2);
    else if (32'(height_r) > 32'(MAX_HEIGHT)) h_c = HW'(MAX_HEIGHT);
    else h_c = HW'(height_r);
  end

  assign in_tready = (state_r == S_IDLE);
  assign ram_we    = (state_r == S_READ);
  assign shift     = ram_we;

  gem_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_top_line (
    .clk(clk), .we(ram_we), .waddr(col_r), .wdata(mid_rd),
    .raddr(col_r), .rdata(top_rd)
  );

  gem_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_mid_line (
    .clk(clk), .we(ram_we), .waddr(col_r), .wdata(v_r),
    .raddr(col_r), .rdata(mid_rd)
  );

  assign new_col = '{v_r, mid_rd, top_rd};

  gem_win_cell u_cell2 (.clk(clk), .shift(shift), .din(new_col), .dout(c2));
  gem_win_cell u_cell1 (.clk(clk), .shift(shift), .din(c2),      .dout(c1));
  gem_win_cell u_cell0 (.clk(clk), .shift(shift), .din(c1),      .dout(c0));

  // position of the window centre and its border flags
  logic               vld;
  logic [31:0]        r_pos, c_pos;
  always_comb begin
    vld = (32'(row_r) >= 32'd2) || (32'(row_r) == 32'd1 && col_r != '0);
    if (col_r == '0) begin
      r_pos = 32'(row_r) - 32'd2;
      c_pos = 32'(w_c) - 32'd1;
    end else begin
      r_pos = 32'(row_r) - 32'd1;
      c_pos = 32'(col_r) - 32'd1;
    end
  end

  // masked window and kernel sums
  logic signed [11:0] gx_c, gy_c;
  logic signed [11:0] p [9];
  kernel_t            kx, ky;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p[i*3+0] = (rz_r && i == 0) || (rh_r && i == 2) || cz_r ? '0 : 12'(c0[i]);
      p[i*3+1] = (rz_r && i == 0) || (rh_r && i == 2) ? '0 : 12'(c1[i]);
      p[i*3+2] = (rz_r && i == 0) || (rh_r && i == 2) || cw_r ? '0 : 12'(c2[i]);
    end
    kx = (method_r == METHOD_PREWITT) ? K_PREW_X : K_SOBEL_X;
    ky = (method_r == METHOD_PREWITT) ? K_PREW_Y : K_SOBEL_Y;
    gx_c = '0;
    gy_c = '0;
    if (method_r == METHOD_ROBERTS) begin
      gx_c = p[0] - p[4];
      gy_c = p[1] - p[3];
    end else begin
      for (int k = 0; k < 9; k++) begin
        gx_c = gx_c + 12'(kx[k]) * p[k];
        gy_c = gy_c + 12'(ky[k]) * p[k];
      end
    end
  end

  function automatic pix_t abs_sat(logic signed [11:0] g);
    logic [11:0] a;
    a = g[11] ? 12'(-g) : 12'(g);
    return (a > 12'd255) ? 8'd255 : a[7:0];
  endfunction

  logic [7:0]  trial;
  logic [15:0] trial_sq;
  logic [16:0] mm_c;
  always_comb begin
    trial    = m_r | (8'd1 << bit_r);
    trial_sq = 16'(trial) * 16'(trial);
    mm_c     = 17'(16'(m_r) * 16'(m_r)) + 17'(m_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      method_r    <= METHOD_SOBEL;
      dir_r       <= DIR_MAG;
      width_r     <= CFG_W'(640);
      height_r    <= CFG_W'(480);
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_METHOD: method_r <= cfg_wdata[1:0];
          REG_DIR:    dir_r    <= cfg_wdata[1:0];
          REG_WIDTH: begin
            width_r <= cfg_wdata;
            col_r   <= '0;
            row_r   <= '0;
          end
          REG_HEIGHT: begin
            height_r <= cfg_wdata;
            col_r    <= '0;
            row_r    <= '0;
          end
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            v_r     <= (in_tuser || 32'(row_r) >= 32'(h_c)) ? 8'd0 : in_tdata;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          rz_r   <= (r_pos == 32'd0);
          rh_r   <= (r_pos == 32'(h_c) - 32'd1);
          cz_r   <= (c_pos == 32'd0);
          cw_r   <= (c_pos == 32'(w_c) - 32'd1);
          last_r <= vld && r_pos == 32'(h_c) - 32'd1 && c_pos == 32'(w_c) - 32'd1;
          if (vld && r_pos == 32'(h_c) - 32'd1 && c_pos == 32'(w_c) - 32'd1) begin
            col_r <= '0;
            row_r <= '0;
          end else if (32'(col_r) + 32'd1 >= 32'(w_c)) begin
            col_r <= '0;
            row_r <= row_r + RW'(1);
          end else begin
            col_r <= col_r + CW'(1);
          end
          state_r <= vld ? S_CALC : S_IDLE;
        end
        S_CALC: begin
          gx_r    <= gx_c;
          gy_r    <= gy_c;
          state_r <= S_SEL;
        end
        S_SEL: begin
          if (dir_r == DIR_X) begin
            res_r   <= abs_sat(gx_r);
            state_r <= S_DONE;
          end else if (dir_r == DIR_Y) begin
            res_r   <= abs_sat(gy_r);
            state_r <= S_DONE;
          end else begin
            sx_r    <= 22'(gx_r) * 22'(gx_r);
            sy_r    <= 22'(gy_r) * 22'(gy_r);
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          n_r     <= sx_r + sy_r;
          m_r     <= '0;
          bit_r   <= 3'd7;
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          // one result bit per cycle, msb first
          if (22'(trial_sq) <= n_r) begin
            m_r <= trial;
          end
          bit_r <= bit_r - 3'd1;
          if (bit_r == 3'd0) begin
            state_r <= S_RND;
          end
        end
        S_RND: begin
          if (n_r >= 22'd65281) res_r <= 8'd255;
          else if (n_r > 22'(mm_c)) res_r <= m_r + 8'd1;
          else res_r <= m_r;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            out_last_r  <= last_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_col_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    32'(col_r) < 32'(w_c) || $past(cfg_we))
    else $error("column counter past line width");

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_DONE))
    else $error("result register loaded outside completion");

  a_root_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROOT && bit_r == 3'd0) |=> state_r == S_RND)
    else $error("square root did not finish after eight steps");

endmodule

>>> sim/gem_checker.sv
// ----------------------------------------------------------------------------
// gem_checker
// Watches the pixel, result and register ports of the gradient edge block,
// predicts every edge value from its own copy of the line buffers and window,
// and compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module gem_checker #(
  parameter int MAX_W = 1024,
  parameter int MAX_H = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [7:0]                in_tdata,
  input  logic                      in_tuser,
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [7:0]                out_tdata,
  input  logic                      out_tlast,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_addr,
  input  logic [gem_pkg::CFG_W-1:0] cfg_wdata,
  output int                        fail_count,
  output int                        pending,
  output int                        pixels_seen,
  output int                        edges_seen,
  output int                        frames_seen
);

  import gem_pkg::*;

  typedef struct packed {
    logic [7:0] edge_value;
    logic       frame_last;
  } edge_res_t;

  edge_res_t  edge_q[$];
  logic [7:0] line_buf[2*MAX_W];
  logic [7:0] win[9];
  logic [1:0] method, direction;
  logic [10:0] width_reg, height_reg;
  int         col_pos, row_pos;

  assign pending = edge_q.size();

  function automatic int sat_abs(int g);
    int a;
    a = (g < 0) ? -g : g;
    return (a > 255) ? 255 : a;
  endfunction

  function automatic int round_mag(int n);
    int m;
    m = 0;
    if (n >= 65281) return 255;
    while ((m + 1) * (m + 1) <= n) m++;
    if (n > m * m + m) m++;
    return (m > 255) ? 255 : m;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch @%0t: %s got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic predict_edge(logic cmd, logic [7:0] pix);
    int w, h, col, r, c, gx, gy, cw, res;
    int p[9];
    logic [7:0] v, top, mid;
    logic valid, last;
    w = (width_reg < 2) ? 2 : (width_reg > MAX_W) ? MAX_W : width_reg;
    h = (height_reg < 2) ? 2 : (height_reg > MAX_H) ? MAX_H : height_reg;
    col = (col_pos >= w) ? w - 1 : col_pos;
    v = (cmd || row_pos >= h) ? 8'd0 : pix;
    top = line_buf[col];
    mid = line_buf[MAX_W + col];
    line_buf[col] = mid;
    line_buf[MAX_W + col] = v;
    for (int i = 0; i < 3; i++) begin
      win[i*3] = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = v;
    valid = (row_pos >= 2) || (row_pos == 1 && col >= 1);
    last = 1'b0;
    if (valid) begin
      if (col == 0) begin
        r = row_pos - 2;
        c = w - 1;
      end else begin
        r = row_pos - 1;
        c = col - 1;
      end
      // zero padding outside the image
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          p[i*3+j] = ((i == 0 && r == 0) || (i == 2 && r == h - 1) ||
                      (j == 0 && c == 0) || (j == 2 && c == w - 1)) ? 0 : win[i*3+j];
      if (method == METHOD_ROBERTS) begin
        gx = p[0] - p[4];
        gy = p[1] - p[3];
      end else begin
        cw = (method == METHOD_PREWITT) ? 1 : 2;
        gx = (p[2] + cw * p[5] + p[8]) - (p[0] + cw * p[3] + p[6]);
        gy = (p[6] + cw * p[7] + p[8]) - (p[0] + cw * p[1] + p[2]);
      end
      if (direction == DIR_X) res = sat_abs(gx);
      else if (direction == DIR_Y) res = sat_abs(gy);
      else res = round_mag(gx * gx + gy * gy);
      last = (r == h - 1) && (c == w - 1);
      edge_q.push_back('{edge_value: res[7:0], frame_last: last});
    end
    if (last) begin
      col_pos = 0;
      row_pos = 0;
    end else begin
      col_pos = col + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
    end
  endtask

  initial begin
    fail_count = 0;
    pixels_seen = 0;
    edges_seen = 0;
    frames_seen = 0;
  end

  always @(posedge clk) begin
    edge_res_t want;
    if (!rst_n) begin
      method = METHOD_SOBEL;
      direction = DIR_MAG;
      width_reg = 11'd640;
      height_reg = 11'd480;
      foreach (line_buf[i]) line_buf[i] = 8'd0;
      foreach (win[i]) win[i] = 8'd0;
      col_pos = 0;
      row_pos = 0;
      edge_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_METHOD: method = cfg_wdata[1:0];
          REG_DIR:    direction = cfg_wdata[1:0];
          REG_WIDTH: begin
            width_reg = cfg_wdata;
            col_pos = 0;
            row_pos = 0;
          end
          REG_HEIGHT: begin
            height_reg = cfg_wdata;
            col_pos = 0;
            row_pos = 0;
          end
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        edges_seen++;
        if (edge_q.size() == 0) begin
          report("unexpected edge transfer", out_tdata, -1);
        end else begin
          want = edge_q.pop_front();
          if (out_tdata !== want.edge_value) report("edge_value", out_tdata, want.edge_value);
          if (out_tlast !== want.frame_last) report("frame_last", out_tlast, want.frame_last);
          if (want.frame_last) frames_seen++;
        end
      end
      if (in_tvalid && in_tready) begin
        pixels_seen++;
        predict_edge(in_tuser, in_tdata);
      end
    end
  end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives raster frames through the gradient edge block under all kernel and
// direction settings and frame sizes, with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import gem_pkg::*;

  localparam logic [1:0] SEL_UNUSED     = 2'd3;

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tuser;
  logic [7:0] in_tdata;
  logic out_tvalid, out_tready, out_tlast;
  logic [7:0] out_tdata;
  logic cfg_we;
  logic [1:0] cfg_addr;
  logic [CFG_W-1:0] cfg_wdata;

  int fail_count, pending, pixels_seen, edges_seen, frames_seen;
  int idle_in, idle_out;
  logic long_hold_go;
  int sent;

  gradient_edge_magnitude_top u_dut (.*);

  gem_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random stalls, plus one long hold-off
  initial begin
    int hold_left;
    bit hold_done;
    out_tready = 1'b0;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (long_hold_go && !hold_done) begin
        hold_done = 1;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= idle_out);
      end
    end
  end

  task automatic send(logic cmd, logic [7:0] pix);
    while ($urandom_range(99) < idle_in) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= pix;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // items that make no result may still be inside
    repeat (64) @(posedge clk);
  endtask

  task automatic set_cfg(logic [1:0] m, logic [1:0] d, int w, int h);
    cfg_we <= 1'b1;
    cfg_addr <= REG_METHOD;
    cfg_wdata <= CFG_W'(m);
    @(posedge clk);
    cfg_addr <= REG_DIR;
    cfg_wdata <= CFG_W'(d);
    @(posedge clk);
    cfg_addr <= REG_WIDTH;
    cfg_wdata <= CFG_W'(w);
    @(posedge clk);
    cfg_addr <= REG_HEIGHT;
    cfg_wdata <= CFG_W'(h);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one frame; pattern 1 alternates black and white, stop_at cuts it short
  task automatic run_frame(int w, int h, int pattern, int stop_at);
    int we, he, n;
    logic [7:0] pix;
    we = (w < 2) ? 2 : (w > 1024) ? 1024 : w;
    he = (h < 2) ? 2 : (h > 1024) ? 1024 : h;
    n = 0;
    for (int i = 0; i < we * he + we + 1; i++) begin
      if (stop_at >= 0 && n >= stop_at) return;
      pix = (pattern == 1) ? (((i + i / we) & 1) ? 8'hFF : 8'h00) : 8'($urandom);
      if (i < we * he) send($urandom_range(19) == 0, pix);  // flush tick inside frame
      else send($urandom_range(9) != 0, pix);  // stray real pixel in flush zone
      n++;
    end
  endtask

  task automatic random_phase(int items);
    int start, w, h;
    start = sent;
    while (sent - start < items) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
      h = $urandom_range(2, 6);
      set_cfg(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), w, h);
      if ($urandom_range(7) == 0) run_frame(w, h, 0, $urandom_range(1, 20));
      else run_frame(w, h, ($urandom_range(5) == 0) ? 1 : 0, -1);
      drain();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = 1'b0;
    in_tdata = 8'd0;
    cfg_we = 1'b0;
    cfg_addr = REG_METHOD;
    cfg_wdata = '0;
    idle_in = 15;
    idle_out = 84;
    long_hold_go = 1'b0;
    sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every kernel and direction, unused codes, clamped sizes
    set_cfg(METHOD_SOBEL, DIR_MAG, 3, 2);
    run_frame(3, 2, 1, -1);
    drain();
    set_cfg(METHOD_ROBERTS, DIR_X, 1, 0);
    run_frame(1, 0, 1, -1);
    drain();
    set_cfg(METHOD_PREWITT, DIR_Y, 2, 2);
    run_frame(2, 2, 1, -1);
    drain();
    set_cfg(SEL_UNUSED, SEL_UNUSED, 2, 2);
    run_frame(2, 2, 0, -1);
    drain();

    random_phase(240);
    idle_in = 84;
    idle_out = 15;
    random_phase(240);
    idle_in = 0;
    idle_out = 0;
    long_hold_go = 1'b1;
    random_phase(240);

    // wide and tall frames cut short, size registers past the maximum
    set_cfg(METHOD_SOBEL, DIR_MAG, 2047, 2);
    run_frame(2047, 2, 0, 500);
    drain();
    set_cfg(METHOD_PREWITT, DIR_X, 2, 2047);
    run_frame(2, 2047, 0, 100);
    drain();

    $display("covered %0d pixel transfers, %0d edge transfers, %0d complete frames",
             pixels_seen, edges_seen, frames_seen);
    $display("all kernels, directions, clamped and extreme sizes, stalls on both sides");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/gem_pkg.sv
design/gem_ram.sv
design/gem_win_cell.sv
design/gradient_edge_magnitude_top.sv
sim/gem_checker.sv
sim/testbench.sv
